>>> sv/float_token_recognizer_top_macros.svh
// Assertion macros for the float token recognizer.
// Used by float_token_recognizer_top; expects i_clk and i_rst_n in scope.
`ifndef FLOAT_TOKEN_RECOGNIZER_TOP_MACROS_SVH
`define FLOAT_TOKEN_RECOGNIZER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FTR_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FTR_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> sv/ftr_pkg.sv
// Package for the float token recognizer: phase encoding, parse-step record,
// character classes and the one-character parse step. No dependencies.
`timescale 1ns / 1ps

package ftr_pkg;

    localparam int MAX_TOKEN = 512;
    localparam int CNT_W     = $clog2(MAX_TOKEN);
    localparam int WP_W      = 4;

    typedef enum logic [9:0] {
        PH_START     = 10'b00_0000_0001,
        PH_GOTSIGN   = 10'b00_0000_0010,
        PH_INF       = 10'b00_0000_0100,
        PH_NAN       = 10'b00_0000_1000,
        PH_NANDONE   = 10'b00_0001_0000,
        PH_MAYBEHEX  = 10'b00_0010_0000,
        PH_DIGITS    = 10'b00_0100_0000,
        PH_FRAC      = 10'b00_1000_0000,
        PH_EXP       = 10'b01_0000_0000,
        PH_EXPDIGITS = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        t_phase            phase;
        logic [WP_W-1:0]   wp;
        logic              ms;
        logic              hex;
        logic              acc;
        logic              cm;
    } t_parse;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_xdig(input logic [7:0] c);
        return is_dig(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_dig(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    // Lowercase letters of "nfinity"
    function automatic logic [7:0] inf_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = "n";
            3'd1:    ch = "f";
            3'd2:    ch = "i";
            3'd3:    ch = "n";
            3'd4:    ch = "i";
            3'd5:    ch = "t";
            default: ch = "y";
        endcase
        return ch;
    endfunction

    // One character through the parser; phases fall through in forward order.
    function automatic t_parse parse_step(input t_parse cur, input logic [7:0] c);
        t_parse     st;
        logic       done;
        logic       dig_ok;
        logic [7:0] lo;
        st     = cur;
        st.acc = 1'b0;
        st.cm  = 1'b0;
        done   = 1'b0;
        dig_ok = (st.hex && is_xdig(c)) || is_dig(c);
        lo     = inf_char(st.wp[2:0]);

        if (st.phase == PH_START) begin
            st.phase = PH_GOTSIGN;
            if (c == "-" || c == "+") begin
                done   = 1'b1;
                st.acc = 1'b1;
            end
        end
        if (!done && st.phase == PH_GOTSIGN) begin
            if (c == "0") begin
                st.phase = PH_MAYBEHEX;
                st.cm    = 1'b1;
                st.acc   = 1'b1;
                done     = 1'b1;
            end else if (c == "i" || c == "I") begin
                st.phase = PH_INF;
                st.acc   = 1'b1;
                done     = 1'b1;
            end else if (c == "n" || c == "N") begin
                st.phase = PH_NAN;
                st.acc   = 1'b1;
                done     = 1'b1;
            end else begin
                st.phase = PH_DIGITS;
            end
        end
        if (!done && st.phase == PH_INF) begin
            done = 1'b1;
            if (st.wp <= WP_W'(6) && (c == lo || c == (lo & 8'hDF))) begin
                st.acc = 1'b1;
                st.cm  = (st.wp == WP_W'(1)) || (st.wp == WP_W'(6));
                st.wp  = st.wp + WP_W'(1);
            end
        end
        if (!done && st.phase == PH_NAN) begin
            done = 1'b1;
            if (st.wp == WP_W'(0)) begin
                st.acc = (c == "a") || (c == "A");
            end else if (st.wp == WP_W'(1)) begin
                st.acc = (c == "n") || (c == "N");
                st.cm  = st.acc;
            end else if (st.wp == WP_W'(2)) begin
                st.acc = (c == "(");
            end else if (c == ")") begin
                st.acc   = 1'b1;
                st.cm    = 1'b1;
                st.phase = PH_NANDONE;
            end else begin
                st.acc = is_alnum(c) || (c == "_");
            end
            if (st.acc && st.wp < WP_W'(3))
                st.wp = st.wp + WP_W'(1);
        end
        if (!done && st.phase == PH_MAYBEHEX) begin
            st.phase = PH_DIGITS;
            if (c == "x" || c == "X") begin
                st.hex = 1'b1;
                st.acc = 1'b1;
                done   = 1'b1;
            end else begin
                st.ms = 1'b1;
            end
        end
        if (!done && st.phase == PH_DIGITS) begin
            if (dig_ok) begin
                st.ms  = 1'b1;
                st.cm  = 1'b1;
                st.acc = 1'b1;
                done   = 1'b1;
            end else begin
                st.phase = PH_FRAC;
                if (c == ".") begin
                    st.cm  = st.ms;
                    st.acc = 1'b1;
                    done   = 1'b1;
                end
            end
        end
        if (!done && st.phase == PH_FRAC) begin
            done = 1'b1;
            if (((c == "e" || c == "E") && !st.hex) || ((c == "p" || c == "P") && st.hex)) begin
                if (st.ms) begin
                    st.phase = PH_EXP;
                    st.acc   = 1'b1;
                end
            end else if (dig_ok) begin
                st.cm  = 1'b1;
                st.ms  = 1'b1;
                st.acc = 1'b1;
            end
        end
        if (!done && st.phase == PH_EXP) begin
            st.phase = PH_EXPDIGITS;
            if (c == "-" || c == "+") begin
                st.acc = 1'b1;
                done   = 1'b1;
            end
        end
        if (!done && st.phase == PH_EXPDIGITS) begin
            done   = 1'b1;
            st.acc = is_dig(c);
            st.cm  = st.acc;
        end
        return st;
    endfunction

endpackage

>>> sv/float_token_recognizer_top.sv
// Float token recognizer: the result of a closing item is registered, through
// the skid entry when the output is held; throughput 1 item per cycle while
// o_stall is low, set by the single parse-step update of the token state. A
// two-entry output (register + skid) keeps input acceptance registered.
// Synchronous active-low reset clears the token state and output valids, sets
// max_length to 511. Uses ftr_pkg (parse step) and the assertion macros header.
`timescale 1ns / 1ps

module float_token_recognizer_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_char_code,
    input  logic                     i_end_of_input,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [ftr_pkg::CNT_W-1:0] o_accepted_length,
    output logic [ftr_pkg::CNT_W-1:0] o_pushback_count,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int W = ftr_pkg::CNT_W;

    logic [W-1:0]        r_max_length;
    ftr_pkg::t_parse     r_tok;
    ftr_pkg::t_parse     n_tok;
    ftr_pkg::t_parse     step;
    logic [W-1:0]        r_stored, n_stored;
    logic [W-1:0]        r_commit, n_commit;
    logic                r_out_valid;
    logic [W-1:0]        r_out_len, r_out_push;
    logic                r_skid_valid;
    logic [W-1:0]        r_skid_len, r_skid_push;

    logic                in_acc;
    logic                out_take;
    logic                take;
    logic                fin;
    logic [W-1:0]        s1;
    logic [W-1:0]        cnt, cmt;
    logic [W-1:0]        res_len, res_push;
    logic                res_valid;
    ftr_pkg::t_parse     tok_clear;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == 1'b0) ? {{(32-W){1'b0}}, r_max_length} : 32'd0;

    assign o_stall  = r_skid_valid;
    assign in_acc   = i_valid && !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign out_take = r_out_valid && !i_stall;
    assign o_accepted_length = r_out_len;
    assign o_pushback_count  = r_out_push;

    always_comb begin
        tok_clear       = '0;
        tok_clear.phase = ftr_pkg::PH_START;
        step = ftr_pkg::parse_step(r_tok, i_char_code);
        s1   = r_stored + W'(1);
        take = !i_end_of_input && (r_stored < r_max_length) && step.acc;
        cnt  = take ? s1 : r_stored;
        cmt  = (take && step.cm) ? s1 : r_commit;
        fin  = !take || (s1 >= r_max_length);
        res_len   = cmt;
        res_push  = cnt - cmt;
        res_valid = in_acc && fin;
        if (!in_acc) begin
            n_tok    = r_tok;
            n_stored = r_stored;
            n_commit = r_commit;
        end else if (fin) begin
            n_tok    = tok_clear;
            n_stored = '0;
            n_commit = '0;
        end else begin
            n_tok    = step;
            n_stored = cnt;
            n_commit = cmt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= W'(511);
            r_tok        <= tok_clear;
            r_stored     <= '0;
            r_commit     <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
                r_max_length <= pwdata[W-1:0];
            r_tok    <= n_tok;
            r_stored <= n_stored;
            r_commit <= n_commit;
            if (out_take || !r_out_valid) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= res_valid;
                end
            end else if (res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_len  <= r_skid_len;
                r_out_push <= r_skid_push;
            end else begin
                r_out_len  <= res_len;
                r_out_push <= res_push;
            end
        end else if (res_valid) begin
            r_skid_len  <= res_len;
            r_skid_push <= res_push;
        end
    end

`include "float_token_recognizer_top_macros.svh"

    `FTR_ASSERT_NOW(a_commit_le_stored, 1'b1, r_commit <= r_stored, "commit past stored count")
    `FTR_ASSERT_NOW(a_skid_implies_out, r_skid_valid, r_out_valid, "skid full, output empty")
    `FTR_ASSERT_NEXT(a_eoi_clears, in_acc && i_end_of_input,
        r_stored == '0 && r_tok.phase == ftr_pkg::PH_START, "token not cleared at end")

endmodule

>>> test/ftr_token_checker.sv
// Result checker for float_token_recognizer_top: watches the item and result channels
// and the max_length register writes, predicts each token result and compares in order.
// Depends on ftr_pkg for the phase encoding and counter width.
`timescale 1ns / 1ps

module ftr_token_checker #(
    parameter logic [2:0] MAX_LENGTH_ADDR = 3'd0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [7:0]                i_char_code,
    input  logic                      i_end_of_input,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [ftr_pkg::CNT_W-1:0] i_accepted_length,
    input  logic [ftr_pkg::CNT_W-1:0] i_pushback_count,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic                      i_pready,
    input  logic [2:0]                i_paddr,
    input  logic [31:0]               i_pwdata,
    output int                        o_mismatch_count,
    output int                        o_pending_count
);

    localparam logic [ftr_pkg::CNT_W-1:0] MAX_LENGTH_RESET = 9'd511;
    localparam string                     INF_TAIL         = "nfinity";

    typedef struct packed {
        logic [ftr_pkg::CNT_W-1:0] accepted_length;
        logic [ftr_pkg::CNT_W-1:0] pushback_count;
    } t_token_result;

    t_token_result             expected_tokens[$];
    int                        mismatch_total = 0;
    int                        pending_total  = 0;
    logic [ftr_pkg::CNT_W-1:0] length_limit;
    ftr_pkg::t_phase           scan_phase;
    logic [3:0]                word_pos;
    logic [ftr_pkg::CNT_W-1:0] chars_stored;
    logic [ftr_pkg::CNT_W-1:0] commit_len;
    logic                      mantissa_seen;
    logic                      hex_mode;

    assign o_mismatch_count = mismatch_total;
    assign o_pending_count  = pending_total;

    function automatic logic is_decimal(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_hex_digit(input logic [7:0] c);
        return is_decimal(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic is_payload_char(input logic [7:0] c);
        return is_decimal(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"))
            || (c == "_");
    endfunction

    function automatic void clear_token();
        scan_phase    = ftr_pkg::PH_START;
        word_pos      = '0;
        chars_stored  = '0;
        commit_len    = '0;
        mantissa_seen = 1'b0;
        hex_mode      = 1'b0;
    endfunction

    function automatic void mark_commit();
        commit_len = chars_stored + 1'b1;
    endfunction

    // Returns 1 when the character extends the token.
    function automatic logic scan_char(input logic [7:0] c);
        logic       again;
        logic       took;
        logic [7:0] lc;
        again = 1'b1;
        took  = 1'b0;
        while (again) begin
            again = 1'b0;
            case (scan_phase)
                ftr_pkg::PH_START: begin
                    scan_phase = ftr_pkg::PH_GOTSIGN;
                    if (c == "-" || c == "+") took = 1'b1;
                    else again = 1'b1;
                end
                ftr_pkg::PH_GOTSIGN: begin
                    took = 1'b1;
                    if (c == "0") begin
                        scan_phase = ftr_pkg::PH_MAYBEHEX;
                        mark_commit();
                    end else if (c == "i" || c == "I") begin
                        scan_phase = ftr_pkg::PH_INF;
                    end else if (c == "n" || c == "N") begin
                        scan_phase = ftr_pkg::PH_NAN;
                    end else begin
                        scan_phase = ftr_pkg::PH_DIGITS;
                        took       = 1'b0;
                        again      = 1'b1;
                    end
                end
                ftr_pkg::PH_INF: begin
                    if (word_pos <= 4'd6) begin
                        lc = INF_TAIL[word_pos];
                        if (c == lc || c == lc - 8'h20) begin
                            took = 1'b1;
                            if (word_pos == 4'd1 || word_pos == 4'd6) mark_commit();
                            word_pos = word_pos + 1'b1;
                        end
                    end
                end
                ftr_pkg::PH_NAN: begin
                    if (word_pos == 4'd0) begin
                        took = (c == "a" || c == "A");
                    end else if (word_pos == 4'd1) begin
                        took = (c == "n" || c == "N");
                        if (took) mark_commit();
                    end else if (word_pos == 4'd2) begin
                        took = (c == "(");
                    end else if (c == ")") begin
                        took       = 1'b1;
                        scan_phase = ftr_pkg::PH_NANDONE;
                        mark_commit();
                    end else begin
                        took = is_payload_char(c);
                    end
                    // payload position saturates
                    if (took && word_pos < 4'd3) word_pos = word_pos + 1'b1;
                end
                ftr_pkg::PH_MAYBEHEX: begin
                    scan_phase = ftr_pkg::PH_DIGITS;
                    if (c == "x" || c == "X") begin
                        hex_mode = 1'b1;
                        took     = 1'b1;
                    end else begin
                        mantissa_seen = 1'b1;
                        again         = 1'b1;
                    end
                end
                ftr_pkg::PH_DIGITS: begin
                    if ((hex_mode && is_hex_digit(c)) || is_decimal(c)) begin
                        mantissa_seen = 1'b1;
                        took          = 1'b1;
                    end else begin
                        scan_phase = ftr_pkg::PH_FRAC;
                        if (c == ".") took = 1'b1;
                        else again = 1'b1;
                    end
                    if (took && mantissa_seen) mark_commit();
                end
                ftr_pkg::PH_FRAC: begin
                    if (((c == "e" || c == "E") && !hex_mode) ||
                        ((c == "p" || c == "P") && hex_mode)) begin
                        if (mantissa_seen) begin
                            scan_phase = ftr_pkg::PH_EXP;
                            took       = 1'b1;
                        end
                    end else if ((hex_mode && is_hex_digit(c)) || is_decimal(c)) begin
                        mark_commit();
                        mantissa_seen = 1'b1;
                        took          = 1'b1;
                    end
                end
                ftr_pkg::PH_EXP: begin
                    scan_phase = ftr_pkg::PH_EXPDIGITS;
                    if (c == "-" || c == "+") took = 1'b1;
                    else again = 1'b1;
                end
                ftr_pkg::PH_EXPDIGITS: begin
                    took = is_decimal(c);
                    if (took) mark_commit();
                end
                default: begin
                    took = 1'b0;
                end
            endcase
        end
        return took;
    endfunction

    // Returns 1 when the item closes the token; res then holds its result.
    function automatic logic token_step(input logic [7:0] c, input logic eoi,
                                        output t_token_result res);
        logic ends;
        ends = 1'b0;
        res  = '0;
        if (eoi || chars_stored >= length_limit) begin
            ends = 1'b1;
        end else if (!scan_char(c)) begin
            ends = 1'b1;
        end else begin
            chars_stored = chars_stored + 1'b1;
            ends         = (chars_stored >= length_limit);
        end
        if (ends) begin
            res.accepted_length = commit_len;
            res.pushback_count  = chars_stored - commit_len;
            clear_token();
        end
        return ends;
    endfunction

    always @(posedge i_clk) begin
        t_token_result tok;
        if (!i_rst_n) begin
            length_limit = MAX_LENGTH_RESET;
            clear_token();
            expected_tokens.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == MAX_LENGTH_ADDR)
                length_limit = i_pwdata[ftr_pkg::CNT_W-1:0];
            if (i_in_valid && !i_in_stall) begin
                if (token_step(i_char_code, i_end_of_input, tok))
                    expected_tokens.push_back(tok);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_tokens.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: unexpected result, expected none, got length %0d pushback %0d",
                             $time, i_accepted_length, i_pushback_count);
                end else begin
                    tok = expected_tokens.pop_front();
                    if (tok.accepted_length !== i_accepted_length) begin
                        mismatch_total++;
                        $display("%0t: accepted_length expected %0d, got %0d",
                                 $time, tok.accepted_length, i_accepted_length);
                    end
                    if (tok.pushback_count !== i_pushback_count) begin
                        mismatch_total++;
                        $display("%0t: pushback_count expected %0d, got %0d",
                                 $time, tok.pushback_count, i_pushback_count);
                    end
                end
            end
        end
        pending_total <= expected_tokens.size();
    end

endmodule

>>> test/float_token_recognizer_top_tb.sv
// Testbench top for float_token_recognizer_top: clock, reset, character stimulus,
// result-side stall and max_length writes; the verdict comes from ftr_token_checker.
`timescale 1ns / 1ps

module float_token_recognizer_top_tb;

    localparam int         CLK_PERIOD      = 20;
    localparam int         RESET_CYCLES    = 11;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         PHASE_ITEMS     = 66;
    localparam int         NUM_PHASES      = 9;
    localparam int         CALM_PHASE      = 4;
    localparam int         HOLD_CYCLES     = 120;
    localparam int         SETTLE_CYCLES   = 4;
    localparam int         DRAIN_CYCLES    = 8;
    localparam logic [2:0] ADDR_MAX_LENGTH = 3'd0;
    localparam string      DIGIT_SET       = "0123456789abcdefABCDEF";
    localparam string      PAYLOAD_SET     =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam int         PAYLOAD_LAST    = 62;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic [7:0]                i_char_code;
    logic                      i_end_of_input;
    logic                      o_valid;
    logic                      i_stall;
    logic [ftr_pkg::CNT_W-1:0] o_accepted_length;
    logic [ftr_pkg::CNT_W-1:0] o_pushback_count;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [2:0]                paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;

    int mismatch_count;
    int pending_count;
    int items_sent   = 0;
    int cycle_count  = 0;
    bit calm         = 1'b0;
    bit hold_request = 1'b0;

    float_token_recognizer_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_char_code       (i_char_code),
        .i_end_of_input    (i_end_of_input),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_accepted_length (o_accepted_length),
        .o_pushback_count  (o_pushback_count),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    ftr_token_checker #(
        .MAX_LENGTH_ADDR (ADDR_MAX_LENGTH)
    ) token_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_char_code       (i_char_code),
        .i_end_of_input    (i_end_of_input),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_accepted_length (o_accepted_length),
        .i_pushback_count  (o_pushback_count),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_pready          (pready),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .o_mismatch_count  (mismatch_count),
        .o_pending_count   (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // result side: random stall, a long hold-off on request, none while calm
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < 17);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    task automatic send_item(input logic [7:0] c, input logic eoi);
        if (!calm && $urandom_range(99) < 17) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_char_code    <= c;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) send_item(text[i], 1'b0);
    endtask

    task automatic send_digits(input int count, input bit hex);
        repeat (count) send_item(DIGIT_SET[$urandom_range(hex ? 21 : 9)], 1'b0);
    endtask

    task automatic send_sign();
        int pick;
        pick = $urandom_range(3);
        if (pick == 1) send_item("+", 1'b0);
        else if (pick == 2) send_item("-", 1'b0);
    endtask

    task automatic send_random_token();
        int         kind;
        int         len;
        int         pick;
        bit         hex_form;
        bit         exp_hex;
        logic [7:0] ch;
        string      word;
        kind = $urandom_range(99);
        if (kind < 12) begin
            repeat ($urandom_range(1, 4)) send_item(8'($urandom_range(255)), 1'b0);
        end else begin
            send_sign();
            if (kind < 72) begin
                hex_form = (kind >= 52);
                if (hex_form) begin
                    send_item("0", 1'b0);
                    send_item($urandom_range(1) ? "x" : "X", 1'b0);
                end
                send_digits($urandom_range(4), hex_form);
                if ($urandom_range(1)) begin
                    send_item(".", 1'b0);
                    send_digits($urandom_range(3), hex_form);
                end
                if ($urandom_range(9) < 4) begin
                    exp_hex = hex_form ^ ($urandom_range(99) < 15);
                    ch      = exp_hex ? "p" : "e";
                    if ($urandom_range(1)) ch = ch - 8'h20;
                    send_item(ch, 1'b0);
                    send_sign();
                    send_digits($urandom_range(3), 1'b0);
                end
            end else begin
                word = (kind < 86) ? "infinity" : "nan";
                len  = $urandom_range(1, word.len());
                for (int i = 0; i < len; i++)
                    send_item(word[i] - ($urandom_range(1) ? 8'h20 : 8'h00), 1'b0);
                if (kind >= 86 && len == 3 && $urandom_range(9) < 7) begin
                    send_item("(", 1'b0);
                    repeat ($urandom_range(14))
                        send_item(PAYLOAD_SET[$urandom_range(PAYLOAD_LAST)], 1'b0);
                    if ($urandom_range(9) < 7) send_item(")", 1'b0);
                end
            end
        end
        pick = $urandom_range(9);
        if (pick < 2) send_item(8'($urandom_range(255)), 1'b1);
        else if (pick < 8) send_item(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_max_length(input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_LENGTH;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        logic [31:0] limits [NUM_PHASES];
        int          phase_start;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_char_code    = 8'h00;
        i_end_of_input = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = ADDR_MAX_LENGTH;
        pwdata         = 32'h0;
        limits         = '{511, 1, 2, 3, 8, 5, 0, 16, 511};
        limits[6]      = $urandom_range(1, 511);
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // exponent with no digits: sign pushed back with the letter
        send_text("-1e+");
        send_item(8'h00, 1'b1);
        // high byte is in no class
        send_text("0xF.p");
        send_item(8'hFF, 1'b0);
        // closed nan payload rejects the next char
        send_text("nan()");
        send_item("x", 1'b0);
        // end of input on an empty token
        send_item("z", 1'b1);
        send_text("iNfiNITY");
        send_item(" ", 1'b0);

        // long result-side hold-off while short tokens keep coming
        hold_request = 1'b1;
        repeat (30) begin
            send_item("7", 1'b0);
            send_item(";", 1'b0);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            write_max_length(limits[p]);
            calm        = (p == CALM_PHASE);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) send_random_token();
        end
        calm = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
